// ----- hdl/lncp_pkg.sv -----
// lncp_pkg: shared types and constants for the line near-clip and projection unit.
// Used by line_near_clip_project_unit. No dependencies.
package lncp_pkg;

	localparam int CFG_WIDTH       = 31;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CENTER_X     = 2'd0,
		REG_CENTER_Y     = 2'd1,
		REG_FOCAL_LENGTH = 2'd2,
		REG_NEAR_DIST    = 2'd3
	} cfg_reg_t;

endpackage

// ----- hdl/lncp_div.sv -----
// lncp_div: pipelined restoring divider, one quotient bit per register stage.
// Dividend must be below den shifted up by QUO_W bits. Standalone, no package needed.
module lncp_div #(
	parameter int DEN_W = 32,
	parameter int QUO_W = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	output logic [QUO_W-1:0]       quo
);

	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] low_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] low_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = num[DEN_W+QUO_W-1:QUO_W];
			assign low_in = num[QUO_W-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign low_in = low_s[k];
			assign quo_in = quo_s[k];
			assign den_in = den_s[k];
		end

		assign trial = {rem_in, low_in[QUO_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k+1] <= {low_in[QUO_W-2:0], 1'b0};
				quo_s[k+1] <= {quo_in[QUO_W-2:0], ge};
				den_s[k+1] <= den_in;
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

// ----- hdl/line_near_clip_project_unit.sv -----
// Line near-plane clip and perspective projection, fully pipelined.
// Accepts one request per cycle while the output register is not stalled; the datapath
// holds two bit-per-stage divider pipelines in series (clip offset, then projection).
// A full output register stalls every stage together; bubbles are not squeezed out.
// arst_n clears the valid bits and loads the register defaults (focal and near = 1.0).
// Depends on lncp_pkg and lncp_div.
module line_near_clip_project_unit
	import lncp_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16,
	parameter int COORD_WIDTH     = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [CFG_WIDTH-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] start_cam_x,
	input  logic signed [COORD_WIDTH-1:0] start_cam_y,
	input  logic signed [COORD_WIDTH-1:0] start_cam_z,
	input  logic signed [COORD_WIDTH-1:0] end_cam_x,
	input  logic signed [COORD_WIDTH-1:0] end_cam_y,
	input  logic signed [COORD_WIDTH-1:0] end_cam_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] screen_start_x,
	output logic signed [COORD_WIDTH-1:0] screen_start_y,
	output logic signed [COORD_WIDTH-1:0] screen_end_x,
	output logic signed [COORD_WIDTH-1:0] screen_end_y
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = ((W > CFG_WIDTH) ? W : CFG_WIDTH) + 1;
	localparam int CW = DW + 1;
	localparam int QW = DW;
	localparam int PW = CFG_WIDTH + W;
	localparam int NW = W + QW;
	localparam int SW = QW + 3;
	localparam logic [CFG_WIDTH-1:0] ONE_RESET = CFG_WIDTH'(64'd1 << COORD_FRAC_BITS);

	typedef logic signed [W-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by;
		coord_t bz;
		logic   clip_a;
		logic   clip_b;
		logic   neg_x;
		logic   neg_y;
	} clip_meta_t;

	typedef struct packed {
		logic [3:0] sat;
		logic [3:0] sub;
	} proj_meta_t;

	logic [CFG_WIDTH-1:0] center_x_q, center_y_q, focal_q, near_q;
	logic en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			focal_q    <= ONE_RESET;
			near_q     <= ONE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:     center_x_q <= cfg_data;
				REG_CENTER_Y:     center_y_q <= cfg_data;
				REG_FOCAL_LENGTH: focal_q    <= cfg_data;
				REG_NEAR_DIST:    near_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: plane test, clip set-up
	logic signed [CW-1:0] plane_e, az_e, bz_e;
	logic behind, clip_a, clip_b, clipping;
	coord_t m_x, m_y, m_z, n_x, n_y, n_z;
	logic signed [CW-1:0] dx_e, dy_e, num_e, den_e, dxa_e, dya_e;

	assign plane_e  = -$signed({{(CW-CFG_WIDTH){1'b0}}, near_q});
	assign az_e     = $signed({{(CW-W){start_cam_z[W-1]}}, start_cam_z});
	assign bz_e     = $signed({{(CW-W){end_cam_z[W-1]}}, end_cam_z});
	assign behind   = (az_e >= plane_e) && (bz_e >= plane_e);
	assign clip_a   = az_e > plane_e;
	assign clip_b   = !clip_a && (bz_e > plane_e);
	assign clipping = clip_a || clip_b;

	assign m_x = clip_a ? start_cam_x : end_cam_x;
	assign m_y = clip_a ? start_cam_y : end_cam_y;
	assign m_z = clip_a ? start_cam_z : end_cam_z;
	assign n_x = clip_a ? end_cam_x : start_cam_x;
	assign n_y = clip_a ? end_cam_y : start_cam_y;
	assign n_z = clip_a ? end_cam_z : start_cam_z;

	assign dx_e  = $signed({{(CW-W){m_x[W-1]}}, m_x}) - $signed({{(CW-W){n_x[W-1]}}, n_x});
	assign dy_e  = $signed({{(CW-W){m_y[W-1]}}, m_y}) - $signed({{(CW-W){n_y[W-1]}}, n_y});
	assign num_e = plane_e - $signed({{(CW-W){n_z[W-1]}}, n_z});
	assign den_e = $signed({{(CW-W){m_z[W-1]}}, m_z}) - $signed({{(CW-W){n_z[W-1]}}, n_z});
	assign dxa_e = dx_e[CW-1] ? -dx_e : dx_e;
	assign dya_e = dy_e[CW-1] ? -dy_e : dy_e;

	logic            valid_s1;
	clip_meta_t      meta_s1;
	logic [DW-1:0]   dxm_s1, dym_s1, num_s1, den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && !behind;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= '{ax: start_cam_x, ay: start_cam_y, az: start_cam_z,
			             bx: end_cam_x, by: end_cam_y, bz: end_cam_z,
			             clip_a: clip_a, clip_b: clip_b,
			             neg_x: dx_e[CW-1], neg_y: dy_e[CW-1]};
			dxm_s1  <= dxa_e[DW-1:0];
			dym_s1  <= dya_e[DW-1:0];
			num_s1  <= clipping ? num_e[DW-1:0] : '0;
			den_s1  <= clipping ? den_e[DW-1:0] : DW'(1);
		end
	end

	// stage 2: clip products
	logic              valid_s2;
	clip_meta_t        meta_s2;
	logic [2*DW-1:0]   px_s2, py_s2;
	logic [DW-1:0]     den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			px_s2   <= dxm_s1 * num_s1;
			py_s2   <= dym_s1 * num_s1;
			den_s2  <= den_s1;
		end
	end

	// clip divide
	logic [DW-1:0] qx, qy;
	logic [DW:1]   valid1_dl;
	clip_meta_t    meta1_dl [1:DW];

	lncp_div #(.DEN_W(DW), .QUO_W(DW)) u_div_clip_x (
		.clk (clk), .en (en), .num (px_s2), .den (den_s2), .quo (qx)
	);
	lncp_div #(.DEN_W(DW), .QUO_W(DW)) u_div_clip_y (
		.clk (clk), .en (en), .num (py_s2), .den (den_s2), .quo (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid1_dl <= '0;
		end else if (en) begin
			valid1_dl <= {valid1_dl[DW-1:1], valid_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta1_dl[1] <= meta_s2;
			for (int k = 2; k <= DW; k++) begin
				meta1_dl[k] <= meta1_dl[k-1];
			end
		end
	end

	// stage 3: clipped endpoint, projection set-up
	clip_meta_t mc;
	coord_t base_x, base_y, clip_x, clip_y, plane_w;
	coord_t fax, fay, faz, fbx, fby, fbz;
	logic signed [CW-1:0] offx, offy;
	logic signed [W:0] nega, negb;
	coord_t fc [4];

	assign mc      = meta1_dl[DW];
	assign base_x  = mc.clip_a ? mc.bx : mc.ax;
	assign base_y  = mc.clip_a ? mc.by : mc.ay;
	assign offx    = mc.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign offy    = mc.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	assign clip_x  = W'($signed({{(CW-W){base_x[W-1]}}, base_x}) + offx);
	assign clip_y  = W'($signed({{(CW-W){base_y[W-1]}}, base_y}) + offy);
	assign plane_w = plane_e[W-1:0];

	assign fax = mc.clip_a ? clip_x  : mc.ax;
	assign fay = mc.clip_a ? clip_y  : mc.ay;
	assign faz = mc.clip_a ? plane_w : mc.az;
	assign fbx = mc.clip_b ? clip_x  : mc.bx;
	assign fby = mc.clip_b ? clip_y  : mc.by;
	assign fbz = mc.clip_b ? plane_w : mc.bz;

	assign nega = -$signed({faz[W-1], faz});
	assign negb = -$signed({fbz[W-1], fbz});

	assign fc[0] = fax;
	assign fc[1] = fay;
	assign fc[2] = fbx;
	assign fc[3] = fby;

	logic          valid_s3;
	logic [W-1:0]  mag_s3 [4];
	logic [3:0]    sub_s3;
	logic [W-1:0]  da_s3, db_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid1_dl[DW];
		end
	end

	// y is flipped: a positive y subtracts from the centre
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				mag_s3[k] <= fc[k][W-1] ? W'(~fc[k] + 1'b1) : fc[k];
			end
			sub_s3 <= {~fby[W-1], fbx[W-1], ~fay[W-1], fax[W-1]};
			da_s3  <= nega[W-1:0];
			db_s3  <= negb[W-1:0];
		end
	end

	// stage 4: projection products
	logic          valid_s4;
	logic [PW-1:0] prod_s4 [4];
	logic [3:0]    sub_s4;
	logic [W-1:0]  da_s4, db_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				prod_s4[k] <= focal_q * mag_s3[k];
			end
			sub_s4 <= sub_s3;
			da_s4  <= da_s3;
			db_s4  <= db_s3;
		end
	end

	// stage 5: overflow test, divider feed
	logic          valid_s5;
	logic [NW-1:0] dnum_s5 [4];
	logic [W-1:0]  dden_s5 [4];
	proj_meta_t    meta_s5;
	logic [3:0]    sat_c;
	logic [NW-1:0] pext [4];
	logic [W-1:0]  dsel [4];

	for (genvar k = 0; k < 4; k++) begin : g_ovf
		assign dsel[k]  = (k < 2) ? da_s4 : db_s4;
		assign pext[k]  = {{(NW-PW){1'b0}}, prod_s4[k]};
		assign sat_c[k] = (prod_s4[k] != '0) && (pext[k] >= {dsel[k], {QW{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				dnum_s5[k] <= sat_c[k] ? '0 : pext[k];
				dden_s5[k] <= (dsel[k] == '0) ? W'(1) : dsel[k];
			end
			meta_s5 <= '{sat: sat_c, sub: sub_s4};
		end
	end

	// projection divide
	logic [QW-1:0] q2 [4];
	logic [QW:1]   valid2_dl;
	proj_meta_t    meta2_dl [1:QW];

	for (genvar k = 0; k < 4; k++) begin : g_pdiv
		lncp_div #(.DEN_W(W), .QUO_W(QW)) u_div_proj (
			.clk (clk), .en (en), .num (dnum_s5[k]), .den (dden_s5[k]), .quo (q2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid2_dl <= '0;
		end else if (en) begin
			valid2_dl <= {valid2_dl[QW-1:1], valid_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta2_dl[1] <= meta_s5;
			for (int k = 2; k <= QW; k++) begin
				meta2_dl[k] <= meta2_dl[k-1];
			end
		end
	end

	// output: centre offset and saturation
	localparam logic signed [SW-1:0] MAX_V = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] MIN_V = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});

	proj_meta_t mp;
	coord_t     res [4];
	coord_t     out_q [4];

	assign mp = meta2_dl[QW];

	for (genvar k = 0; k < 4; k++) begin : g_out
		logic [QW:0]          qf;
		logic [CFG_WIDTH-1:0] ctr;
		logic signed [SW-1:0] qs, sum;

		assign qf  = mp.sat[k] ? {1'b1, {QW{1'b0}}} : {1'b0, q2[k]};
		assign ctr = (k % 2 == 0) ? center_x_q : center_y_q;
		assign qs  = $signed({2'b00, qf});
		assign sum = $signed({{(SW-CFG_WIDTH){1'b0}}, ctr}) + (mp.sub[k] ? -qs : qs);
		assign res[k] = (sum > MAX_V) ? MAX_V[W-1:0] :
		                (sum < MIN_V) ? MIN_V[W-1:0] : sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid2_dl[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				out_q[k] <= res[k];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign screen_start_x = out_q[0];
	assign screen_start_y = out_q[1];
	assign screen_end_x   = out_q[2];
	assign screen_end_y   = out_q[3];

endmodule
